FILE: sv/pbmd_pkg.sv
`timescale 1ns / 1ps

package pbmd_pkg;

    localparam int TILT_W      = 17;
    localparam int ELAPSED_W   = 8;
    localparam int GAIN_W      = 16;
    localparam int SPIN_W      = 9;
    localparam int PERIOD_W    = 8;
    localparam int TIMER_W     = 9;
    localparam int ERR_W       = 18;
    localparam int DIFF_W      = 19;
    localparam int PROD_W      = 34;
    localparam int DPROD_W     = 35;
    localparam int MAG_W       = 32;
    localparam int QI_W        = 26;
    localparam int QD_W        = 30;
    localparam int INC_W       = 27;
    localparam int DTERM_W     = 31;
    localparam int INTEG_W     = 26;
    localparam int INTEG_SUM_W = 28;
    localparam int SUM_W       = 35;
    localparam int PWM_W       = 8;
    localparam int DIR_W       = 2;
    localparam int CV_W        = 16;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam int TIMER_MAX   = 511;
    localparam int RECIP_SHIFT = 32;
    localparam longint RECIP_100 = 42949672;
    localparam longint RECIP_5   = 858993459;
    localparam int INTEG_LIMIT = 255 * 65536;
    localparam int ONE_COUNT_SHIFT = 16;
    localparam int TELE_BIAS   = 254 * 65536;
    localparam int PWM_MAX     = 255;
    localparam int CV_MAX      = 32767;
    localparam int CV_MIN_MAG  = 32768;
    localparam int X_SAT       = 1275;
    localparam int DIV5_RECIP  = 13108;
    localparam int DIV5_SHIFT  = 16;

    localparam int NUM_STAGES = 12;
    localparam int ST_IN    = 0;
    localparam int ST_ERR   = 1;
    localparam int ST_PROD  = 2;
    localparam int ST_ABS   = 3;
    localparam int ST_RECIP = 4;
    localparam int ST_CORR  = 5;
    localparam int ST_SIGN  = 6;
    localparam int ST_INTEG = 7;
    localparam int ST_SUM   = 8;
    localparam int ST_EVAL  = 9;
    localparam int ST_MIX   = 10;
    localparam int ST_OUT   = 11;

    typedef enum logic [2:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DERIV_GAIN   = 3'd2,
        REG_TARGET_ANGLE = 3'd3,
        REG_SPIN_OFFSET  = 3'd4,
        REG_DERIV_PERIOD = 3'd5
    } reg_idx_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   prop_gain;
        logic signed [GAIN_W-1:0]   integ_gain;
        logic signed [GAIN_W-1:0]   deriv_gain;
        logic signed [TILT_W-1:0]   target_angle;
        logic signed [SPIN_W-1:0]   spin_offset;
        logic        [PERIOD_W-1:0] deriv_period_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [TILT_W-1:0]    tilt_angle;
        logic        [ELAPSED_W-1:0] elapsed_ms;
    } sample_t;

    typedef struct packed {
        logic [PWM_W-1:0] motor_a_pwm;
        logic [PWM_W-1:0] motor_b_pwm;
        logic [DIR_W-1:0] drive_direction;
        logic [CV_W-1:0]  control_value;
        logic [PWM_W-1:0] telemetry_byte;
    } drive_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] take;
    } pipe_ctl_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]  p;
        logic signed [PROD_W-1:0]  i;
        logic signed [DPROD_W-1:0] d;
        logic                      fire;
    } prod_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] p;
        logic [QI_W-1:0]          qi;
        logic [QD_W-1:0]          qd;
        logic                     si;
        logic                     sd;
        logic                     fire;
    } quot_t;

endpackage

FILE: sv/pbmd_front.sv
`timescale 1ns / 1ps

module pbmd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  pbmd_pkg::pipe_ctl_t ctl,
    input  pbmd_pkg::cfg_t    cfg,
    input  pbmd_pkg::sample_t sample,
    output pbmd_pkg::prod_t   prod
);

    pbmd_pkg::sample_t sample_reg;

    logic [pbmd_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic signed [pbmd_pkg::ERR_W-1:0] prev_err_reg, prev_err_next;

    logic signed [pbmd_pkg::ERR_W-1:0]  err_next, err_reg;
    logic signed [pbmd_pkg::DIFF_W-1:0] diff_next, diff_reg;
    logic fire_next, fire_reg;
    logic [pbmd_pkg::TIMER_W:0]   timer_sum;
    logic [pbmd_pkg::TIMER_W-1:0] timer_sat;

    pbmd_pkg::prod_t prod_next, prod_reg;

    always_comb
    begin
        err_next  = pbmd_pkg::ERR_W'(sample_reg.tilt_angle)
                  - pbmd_pkg::ERR_W'(cfg.target_angle);
        diff_next = pbmd_pkg::DIFF_W'(err_next) - pbmd_pkg::DIFF_W'(prev_err_reg);
        timer_sum = {1'b0, timer_reg}
                  + (pbmd_pkg::TIMER_W + 1)'(sample_reg.elapsed_ms);
        if (timer_sum > (pbmd_pkg::TIMER_W + 1)'(pbmd_pkg::TIMER_MAX))
        begin
            timer_sat = pbmd_pkg::TIMER_W'(pbmd_pkg::TIMER_MAX);
        end
        else
        begin
            timer_sat = timer_sum[pbmd_pkg::TIMER_W-1:0];
        end
        fire_next     = timer_sat >= pbmd_pkg::TIMER_W'(cfg.deriv_period_ms);
        timer_next    = fire_next ? '0 : timer_sat;
        prev_err_next = fire_next ? err_next : prev_err_reg;
    end

    always_comb
    begin
        prod_next.p    = pbmd_pkg::PROD_W'($signed(cfg.prop_gain))
                       * pbmd_pkg::PROD_W'(err_reg);
        prod_next.i    = pbmd_pkg::PROD_W'($signed(cfg.integ_gain))
                       * pbmd_pkg::PROD_W'(err_reg);
        prod_next.d    = pbmd_pkg::DPROD_W'($signed(cfg.deriv_gain))
                       * pbmd_pkg::DPROD_W'(diff_reg);
        prod_next.fire = fire_reg;
    end

    // derivative timer and last error advance once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg    <= '0;
            prev_err_reg <= '0;
        end
        else if (ctl.take[pbmd_pkg::ST_ERR])
        begin
            timer_reg    <= timer_next;
            prev_err_reg <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[pbmd_pkg::ST_IN])
        begin
            sample_reg <= sample;
        end
        if (ctl.en[pbmd_pkg::ST_ERR])
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
            fire_reg <= fire_next;
        end
        if (ctl.en[pbmd_pkg::ST_PROD])
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: sv/pbmd_div.sv
`timescale 1ns / 1ps

module pbmd_div (
    input  logic                clk,
    input  pbmd_pkg::pipe_ctl_t ctl,
    input  pbmd_pkg::prod_t     prod,
    output pbmd_pkg::quot_t     quot
);

    localparam int PI_W = pbmd_pkg::MAG_W + pbmd_pkg::QI_W;
    localparam int PD_W = pbmd_pkg::MAG_W + pbmd_pkg::QD_W;
    localparam int RI_W = pbmd_pkg::MAG_W + 2;
    localparam int RD_W = pbmd_pkg::MAG_W + 1;

    logic signed [pbmd_pkg::PROD_W-1:0]  i_abs;
    logic signed [pbmd_pkg::DPROD_W-1:0] d_abs;

    logic [pbmd_pkg::MAG_W-1:0] yi_reg, yd_reg, yi2_reg, yd2_reg;
    logic signed [pbmd_pkg::PROD_W-1:0] p_reg, p2_reg;
    logic si_reg, sd_reg, fire_reg, si2_reg, sd2_reg, fire2_reg;

    logic [PI_W-1:0] prod_i;
    logic [PD_W-1:0] prod_d;
    logic [pbmd_pkg::QI_W-1:0] qi0_reg;
    logic [pbmd_pkg::QD_W-1:0] qd0_reg;

    logic [RI_W-1:0] rem_i;
    logic [RD_W-1:0] rem_d;
    pbmd_pkg::quot_t quot_next, quot_reg;

    always_comb
    begin
        i_abs  = prod.i[pbmd_pkg::PROD_W-1] ? -prod.i : prod.i;
        d_abs  = prod.d[pbmd_pkg::DPROD_W-1] ? -prod.d : prod.d;
        // reciprocal estimate, low by at most one
        prod_i = PI_W'(yi_reg) * PI_W'(pbmd_pkg::RECIP_100);
        prod_d = PD_W'(yd_reg) * PD_W'(pbmd_pkg::RECIP_5);
    end

    always_comb
    begin
        rem_i = RI_W'(yi2_reg) - RI_W'(qi0_reg) * RI_W'(100);
        rem_d = RD_W'(yd2_reg) - RD_W'(qd0_reg) * RD_W'(5);
        quot_next.p    = p2_reg;
        quot_next.qi   = qi0_reg + pbmd_pkg::QI_W'(rem_i >= RI_W'(100));
        quot_next.qd   = qd0_reg + pbmd_pkg::QD_W'(rem_d >= RD_W'(5));
        quot_next.si   = si2_reg;
        quot_next.sd   = sd2_reg;
        quot_next.fire = fire2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[pbmd_pkg::ST_ABS])
        begin
            yi_reg   <= i_abs[pbmd_pkg::MAG_W-1:0];
            // divide by ten as halve then divide by five
            yd_reg   <= d_abs[pbmd_pkg::MAG_W:1];
            si_reg   <= prod.i[pbmd_pkg::PROD_W-1];
            sd_reg   <= prod.d[pbmd_pkg::DPROD_W-1];
            p_reg    <= prod.p;
            fire_reg <= prod.fire;
        end
        if (ctl.en[pbmd_pkg::ST_RECIP])
        begin
            qi0_reg   <= prod_i[PI_W-1:pbmd_pkg::RECIP_SHIFT];
            qd0_reg   <= prod_d[PD_W-1:pbmd_pkg::RECIP_SHIFT];
            yi2_reg   <= yi_reg;
            yd2_reg   <= yd_reg;
            si2_reg   <= si_reg;
            sd2_reg   <= sd_reg;
            p2_reg    <= p_reg;
            fire2_reg <= fire_reg;
        end
        if (ctl.en[pbmd_pkg::ST_CORR])
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

FILE: sv/pbmd_accum.sv
`timescale 1ns / 1ps

module pbmd_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  pbmd_pkg::pipe_ctl_t ctl,
    input  pbmd_pkg::quot_t     quot,
    output logic signed [pbmd_pkg::SUM_W-1:0] sum
);

    localparam logic signed [pbmd_pkg::INTEG_SUM_W-1:0] LIM_HI =
        pbmd_pkg::INTEG_SUM_W'(pbmd_pkg::INTEG_LIMIT);
    localparam logic signed [pbmd_pkg::INTEG_SUM_W-1:0] LIM_LO = -LIM_HI;

    logic signed [pbmd_pkg::INC_W-1:0]   inc_next, inc_reg;
    logic signed [pbmd_pkg::DTERM_W-1:0] dterm_next, dterm_reg, dterm2_reg;
    logic signed [pbmd_pkg::PROD_W-1:0]  p_reg, p2_reg;

    logic signed [pbmd_pkg::INTEG_W-1:0]     integ_reg, integ_next, integ_val_reg;
    logic signed [pbmd_pkg::INTEG_SUM_W-1:0] integ_sum;
    logic signed [pbmd_pkg::SUM_W-1:0]       sum_next, sum_reg;

    always_comb
    begin
        inc_next = quot.si ? -$signed({1'b0, quot.qi}) : $signed({1'b0, quot.qi});
        if (!quot.fire)
        begin
            dterm_next = '0;
        end
        else if (quot.sd)
        begin
            dterm_next = -$signed({1'b0, quot.qd});
        end
        else
        begin
            dterm_next = $signed({1'b0, quot.qd});
        end
    end

    always_comb
    begin
        integ_sum = pbmd_pkg::INTEG_SUM_W'(integ_reg) + pbmd_pkg::INTEG_SUM_W'(inc_reg);
        priority if (integ_sum > LIM_HI)
        begin
            integ_next = pbmd_pkg::INTEG_W'(LIM_HI);
        end
        else if (integ_sum < LIM_LO)
        begin
            integ_next = pbmd_pkg::INTEG_W'(LIM_LO);
        end
        else
        begin
            integ_next = integ_sum[pbmd_pkg::INTEG_W-1:0];
        end
    end

    always_comb
    begin
        sum_next = pbmd_pkg::SUM_W'(p2_reg) + pbmd_pkg::SUM_W'(integ_val_reg)
                 + pbmd_pkg::SUM_W'(dterm2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (ctl.take[pbmd_pkg::ST_INTEG])
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[pbmd_pkg::ST_SIGN])
        begin
            inc_reg   <= inc_next;
            dterm_reg <= dterm_next;
            p_reg     <= quot.p;
        end
        if (ctl.en[pbmd_pkg::ST_INTEG])
        begin
            integ_val_reg <= integ_next;
            dterm2_reg    <= dterm_reg;
            p2_reg        <= p_reg;
        end
        if (ctl.en[pbmd_pkg::ST_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

FILE: sv/pbmd_motor.sv
`timescale 1ns / 1ps

module pbmd_motor (
    input  logic                clk,
    input  logic                rst_n,
    input  pbmd_pkg::pipe_ctl_t ctl,
    input  pbmd_pkg::cfg_t      cfg,
    input  logic signed [pbmd_pkg::SUM_W-1:0] sum,
    output pbmd_pkg::drive_t    drive
);

    localparam int HI_W = pbmd_pkg::SUM_W - pbmd_pkg::ONE_COUNT_SHIFT;
    localparam int BS_W = pbmd_pkg::PWM_W + 3;
    localparam int X_W  = 13;
    localparam int XQ_W = 11;
    localparam int XP_W = XQ_W + 14;

    logic signed [pbmd_pkg::SUM_W-1:0] sum_abs, tele_sum;
    logic [HI_W-1:0] hi;
    logic [pbmd_pkg::PWM_W-1:0] mag_next, mag_reg, tele_next, tele_reg, tele2_reg;
    logic [pbmd_pkg::CV_W-1:0]  cv_next, cv_reg, cv2_reg;
    logic zero_reg, neg_reg, zero2_reg, neg2_reg;

    logic signed [BS_W-1:0] b_sum;
    logic [pbmd_pkg::PWM_W-1:0] b_next, b_reg;
    logic signed [X_W-1:0] x_next, x_reg;

    logic [XP_W-1:0] x_prod;
    logic [pbmd_pkg::PWM_W-1:0] a_val;
    logic [pbmd_pkg::PWM_W-1:0] held_a_reg, held_b_reg;
    pbmd_pkg::dir_t held_dir_reg;
    logic [pbmd_pkg::CV_W-1:0]  cv_out_reg;
    logic [pbmd_pkg::PWM_W-1:0] tele_out_reg;

    always_comb
    begin
        sum_abs  = sum[pbmd_pkg::SUM_W-1] ? -sum : sum;
        hi       = sum_abs[pbmd_pkg::SUM_W-1:pbmd_pkg::ONE_COUNT_SHIFT];
        mag_next = (hi > HI_W'(pbmd_pkg::PWM_MAX)) ? pbmd_pkg::PWM_W'(pbmd_pkg::PWM_MAX)
                                                    : hi[pbmd_pkg::PWM_W-1:0];
        if (!sum[pbmd_pkg::SUM_W-1])
        begin
            cv_next = (hi > HI_W'(pbmd_pkg::CV_MAX)) ? pbmd_pkg::CV_W'(pbmd_pkg::CV_MAX)
                                                      : hi[pbmd_pkg::CV_W-1:0];
        end
        else
        begin
            cv_next = (hi > HI_W'(pbmd_pkg::CV_MIN_MAG))
                    ? pbmd_pkg::CV_W'(pbmd_pkg::CV_MIN_MAG)
                    : -hi[pbmd_pkg::CV_W-1:0];
        end
        tele_sum = sum + pbmd_pkg::SUM_W'(pbmd_pkg::TELE_BIAS);
        priority if (tele_sum[pbmd_pkg::SUM_W-1])
        begin
            tele_next = '0;
        end
        else if (tele_sum[pbmd_pkg::SUM_W-1:pbmd_pkg::ONE_COUNT_SHIFT+1]
                 > (HI_W - 1)'(pbmd_pkg::PWM_MAX))
        begin
            tele_next = pbmd_pkg::PWM_W'(pbmd_pkg::PWM_MAX);
        end
        else
        begin
            tele_next = tele_sum[pbmd_pkg::ONE_COUNT_SHIFT+pbmd_pkg::PWM_W:
                                 pbmd_pkg::ONE_COUNT_SHIFT+1];
        end
    end

    // motor b gets the offset, motor a 0.8 of b less the offset, both clamped
    always_comb
    begin
        b_sum = $signed({3'b000, mag_reg}) + BS_W'(cfg.spin_offset);
        priority if (b_sum < 0)
        begin
            b_next = '0;
        end
        else if (b_sum > BS_W'(pbmd_pkg::PWM_MAX))
        begin
            b_next = pbmd_pkg::PWM_W'(pbmd_pkg::PWM_MAX);
        end
        else
        begin
            b_next = b_sum[pbmd_pkg::PWM_W-1:0];
        end
        x_next = $signed({3'b000, b_next, 2'b00})
               - $signed(X_W'(cfg.spin_offset)) * $signed(X_W'(5));
    end

    always_comb
    begin
        x_prod = XP_W'(x_reg[XQ_W-1:0]) * XP_W'(pbmd_pkg::DIV5_RECIP);
        priority if (x_reg >= X_W'(pbmd_pkg::X_SAT))
        begin
            a_val = pbmd_pkg::PWM_W'(pbmd_pkg::PWM_MAX);
        end
        else if (x_reg <= 0)
        begin
            a_val = '0;
        end
        else
        begin
            a_val = x_prod[pbmd_pkg::DIV5_SHIFT+pbmd_pkg::PWM_W-1:pbmd_pkg::DIV5_SHIFT];
        end
    end

    // a zero sum keeps the previous drive
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_a_reg   <= pbmd_pkg::PWM_W'(pbmd_pkg::PWM_MAX);
            held_b_reg   <= pbmd_pkg::PWM_W'(pbmd_pkg::PWM_MAX);
            held_dir_reg <= pbmd_pkg::DIR_STOP;
        end
        else if (ctl.take[pbmd_pkg::ST_OUT] && !zero2_reg)
        begin
            held_a_reg   <= a_val;
            held_b_reg   <= b_reg;
            held_dir_reg <= neg2_reg ? pbmd_pkg::DIR_BACK : pbmd_pkg::DIR_FWD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[pbmd_pkg::ST_EVAL])
        begin
            mag_reg  <= mag_next;
            cv_reg   <= cv_next;
            tele_reg <= tele_next;
            zero_reg <= (sum == '0);
            neg_reg  <= sum[pbmd_pkg::SUM_W-1];
        end
        if (ctl.en[pbmd_pkg::ST_MIX])
        begin
            b_reg     <= b_next;
            x_reg     <= x_next;
            cv2_reg   <= cv_reg;
            tele2_reg <= tele_reg;
            zero2_reg <= zero_reg;
            neg2_reg  <= neg_reg;
        end
        if (ctl.en[pbmd_pkg::ST_OUT])
        begin
            cv_out_reg   <= cv2_reg;
            tele_out_reg <= tele2_reg;
        end
    end

    assign drive.motor_a_pwm     = held_a_reg;
    assign drive.motor_b_pwm     = held_b_reg;
    assign drive.drive_direction = held_dir_reg;
    assign drive.control_value   = cv_out_reg;
    assign drive.telemetry_byte  = tele_out_reg;

endmodule

FILE: sv/pid_balance_motor_drive.sv
`timescale 1ns / 1ps

// balance controller: pid on tilt samples, mapped to two motor pwm duties
// sample channel: valid/ready, one tilt angle and elapsed ms per transaction
// drive channel: valid/ready, pwm a/b, direction, control value, telemetry
// apb port: six registers at byte addresses 0x00..0x14, writes take effect at
// the access cycle, pready is tied high, reads sign-extend all but the period
// throughput: one transaction per cycle while drive_ready holds, set by the
// 12-stage pipeline in which the integral, derivative timer and held drive
// each update in one stage; when the drive receiver stalls, the pipeline
// keeps filling its empty stages and sample_ready drops only once every
// stage holds a transaction; reset clears the integral, last error,
// derivative timer and the pipeline, sets both held duties to 255 with
// direction stopped and loads the default gains; the user, not the block,
// ensures configuration is written only while no transaction is in flight

module pid_balance_motor_drive (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  pbmd_pkg::sample_t                 sample,
    output logic                              drive_valid,
    input  logic                              drive_ready,
    output pbmd_pkg::drive_t                  drive,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbmd_pkg::ADDR_W-1:0]       paddr,
    input  logic [pbmd_pkg::DATA_W-1:0]       pwdata,
    output logic [pbmd_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    pbmd_pkg::cfg_t cfg_reg, cfg_next;
    logic cfg_write;

    logic [pbmd_pkg::NUM_STAGES-1:0] valid_reg, valid_next;
    pbmd_pkg::pipe_ctl_t ctl;

    pbmd_pkg::prod_t prod;
    pbmd_pkg::quot_t quot;
    logic signed [pbmd_pkg::SUM_W-1:0] sum;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[4:2])
                pbmd_pkg::REG_PROP_GAIN:
                    cfg_next.prop_gain = pwdata[pbmd_pkg::GAIN_W-1:0];
                pbmd_pkg::REG_INTEG_GAIN:
                    cfg_next.integ_gain = pwdata[pbmd_pkg::GAIN_W-1:0];
                pbmd_pkg::REG_DERIV_GAIN:
                    cfg_next.deriv_gain = pwdata[pbmd_pkg::GAIN_W-1:0];
                pbmd_pkg::REG_TARGET_ANGLE:
                    cfg_next.target_angle = pwdata[pbmd_pkg::TILT_W-1:0];
                pbmd_pkg::REG_SPIN_OFFSET:
                    cfg_next.spin_offset = pwdata[pbmd_pkg::SPIN_W-1:0];
                pbmd_pkg::REG_DERIV_PERIOD:
                    cfg_next.deriv_period_ms = pwdata[pbmd_pkg::PERIOD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            pbmd_pkg::REG_PROP_GAIN:
                prdata = pbmd_pkg::DATA_W'(cfg_reg.prop_gain);
            pbmd_pkg::REG_INTEG_GAIN:
                prdata = pbmd_pkg::DATA_W'(cfg_reg.integ_gain);
            pbmd_pkg::REG_DERIV_GAIN:
                prdata = pbmd_pkg::DATA_W'(cfg_reg.deriv_gain);
            pbmd_pkg::REG_TARGET_ANGLE:
                prdata = pbmd_pkg::DATA_W'(cfg_reg.target_angle);
            pbmd_pkg::REG_SPIN_OFFSET:
                prdata = pbmd_pkg::DATA_W'(cfg_reg.spin_offset);
            pbmd_pkg::REG_DERIV_PERIOD:
                prdata = pbmd_pkg::DATA_W'(cfg_reg.deriv_period_ms);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= 16'sd2330;
            cfg_reg.integ_gain      <= 16'sd2048;
            cfg_reg.deriv_gain      <= 16'sd1280;
            cfg_reg.target_angle    <= '0;
            cfg_reg.spin_offset     <= '0;
            cfg_reg.deriv_period_ms <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        ctl.en[pbmd_pkg::ST_OUT] = !valid_reg[pbmd_pkg::ST_OUT] || drive_ready;
        for (int i = pbmd_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            ctl.en[i] = !valid_reg[i] || ctl.en[i+1];
        end
        ctl.take[0]   = ctl.en[0] && sample_valid;
        valid_next[0] = ctl.en[0] ? sample_valid : valid_reg[0];
        for (int i = 1; i < pbmd_pkg::NUM_STAGES; i++)
        begin
            ctl.take[i]   = ctl.en[i] && valid_reg[i-1];
            valid_next[i] = ctl.en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_ready = ctl.en[pbmd_pkg::ST_IN];
    assign drive_valid  = valid_reg[pbmd_pkg::ST_OUT];

    pbmd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cfg    (cfg_reg),
        .sample (sample),
        .prod   (prod)
    );

    pbmd_div u_div (
        .clk  (clk),
        .ctl  (ctl),
        .prod (prod),
        .quot (quot)
    );

    pbmd_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .quot  (quot),
        .sum   (sum)
    );

    pbmd_motor u_motor (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cfg   (cfg_reg),
        .sum   (sum),
        .drive (drive)
    );

endmodule

FILE: test/pid_balance_motor_drive_test.sv
`timescale 1ns / 1ps

module pid_balance_motor_drive_test;

    localparam int PHASE_ITEMS = 66;
    localparam int NUM_PHASES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam longint ONE_COUNT = 65536;
    localparam longint TILT_MAX = 46080;

    typedef struct packed {
        logic signed [pbmd_pkg::TILT_W-1:0]    tilt;
        logic        [pbmd_pkg::ELAPSED_W-1:0] elapsed;
        logic                                  typed;
        pbmd_pkg::drive_t                      want;
    } stim_row_t;

    localparam pbmd_pkg::drive_t IDLE_DRIVE =
        '{8'd255, 8'd255, pbmd_pkg::DIR_STOP, 16'd0, 8'd127};
    localparam pbmd_pkg::drive_t NO_DRIVE = '0;

    localparam int NUM_ROWS = 12;
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{17'sd0,      8'd0,   1'b1, IDLE_DRIVE},
        '{17'sd0,      8'd10,  1'b1, IDLE_DRIVE},
        '{17'sd1,      8'd0,   1'b0, NO_DRIVE},
        '{-17'sd1,     8'd0,   1'b0, NO_DRIVE},
        '{17'sd46080,  8'd0,   1'b0, NO_DRIVE},
        '{17'sd46080,  8'd255, 1'b0, NO_DRIVE},
        '{-17'sd46080, 8'd255, 1'b0, NO_DRIVE},
        '{-17'sd46080, 8'd9,   1'b0, NO_DRIVE},
        '{-17'sd46080, 8'd1,   1'b0, NO_DRIVE},
        '{17'sd0,      8'd255, 1'b0, NO_DRIVE},
        '{17'sd32767,  8'd7,   1'b0, NO_DRIVE},
        '{-17'sd32768, 8'd200, 1'b0, NO_DRIVE}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          sample_valid;
    logic                          sample_ready;
    pbmd_pkg::sample_t             sample;
    logic                          drive_valid;
    logic                          drive_ready;
    pbmd_pkg::drive_t              drive;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pbmd_pkg::ADDR_W-1:0]   paddr;
    logic [pbmd_pkg::DATA_W-1:0]   pwdata;
    logic [pbmd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // controller settings and state as the block should hold them
    longint kp, ki, kd, target, spin, period;
    longint integ_acc, last_err, deriv_ms;
    logic [pbmd_pkg::PWM_W-1:0] held_a, held_b;
    pbmd_pkg::dir_t held_dir;

    pbmd_pkg::drive_t expected_q[$];
    int mismatches = 0;
    int cycles = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;

    pid_balance_motor_drive i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .drive_valid  (drive_valid),
        .drive_ready  (drive_ready),
        .drive        (drive),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one pid step: updates the tracked state and returns the drive it yields
    function automatic pbmd_pkg::drive_t next_drive(pbmd_pkg::sample_t s);
        longint err, dterm, total, mag, b, x, cv, tel;
        pbmd_pkg::drive_t d;
        err = longint'($signed(s.tilt_angle)) - target;
        integ_acc = clamp(integ_acc + (ki * err) / 100,
                          -pbmd_pkg::INTEG_LIMIT, pbmd_pkg::INTEG_LIMIT);
        deriv_ms = deriv_ms + longint'(s.elapsed_ms);
        if (deriv_ms > pbmd_pkg::TIMER_MAX)
            deriv_ms = pbmd_pkg::TIMER_MAX;
        dterm = 0;
        if (deriv_ms >= period)
        begin
            dterm = (kd * (err - last_err)) / 10;
            last_err = err;
            deriv_ms = 0;
        end
        total = kp * err + integ_acc + dterm;
        if (total != 0)
        begin
            mag = (total > 0 ? total : -total) / ONE_COUNT;
            if (mag > pbmd_pkg::PWM_MAX)
                mag = pbmd_pkg::PWM_MAX;
            b = clamp(mag + spin, 0, pbmd_pkg::PWM_MAX);
            // motor a is 0.8 of motor b less the offset, kept in fifths
            x = 4 * b - 5 * spin;
            if (x >= pbmd_pkg::X_SAT)
                x = pbmd_pkg::PWM_MAX;
            else if (x <= 0)
                x = 0;
            else
                x = x / 5;
            held_a = pbmd_pkg::PWM_W'(x);
            held_b = pbmd_pkg::PWM_W'(b);
            held_dir = (total > 0) ? pbmd_pkg::DIR_FWD : pbmd_pkg::DIR_BACK;
        end
        cv = clamp(total / ONE_COUNT, -pbmd_pkg::CV_MIN_MAG, pbmd_pkg::CV_MAX);
        tel = total + 254 * ONE_COUNT;
        if (tel < 0)
            tel = 0;
        else
            tel = clamp(tel / (2 * ONE_COUNT), 0, pbmd_pkg::PWM_MAX);
        d.motor_a_pwm = held_a;
        d.motor_b_pwm = held_b;
        d.drive_direction = held_dir;
        d.control_value = pbmd_pkg::CV_W'(cv);
        d.telemetry_byte = pbmd_pkg::PWM_W'(tel);
        return d;
    endfunction

    function automatic longint rand_gain();
        if ($urandom_range(0, 3) != 0)
            return longint'($urandom_range(0, 4096)) - 2048;
        return longint'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic pbmd_pkg::sample_t random_sample();
        pbmd_pkg::sample_t s;
        longint t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            t = longint'($urandom_range(0, 32'(2 * TILT_MAX))) - TILT_MAX;
        else if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0: t = TILT_MAX;
                1: t = -TILT_MAX;
                2: t = 0;
                default: t = target;
            endcase
        end
        else
            t = clamp(target + longint'($urandom_range(0, 600)) - 300,
                      -TILT_MAX, TILT_MAX);
        s.tilt_angle = pbmd_pkg::TILT_W'(t);
        if ($urandom_range(0, 99) < 70)
            s.elapsed_ms = pbmd_pkg::ELAPSED_W'($urandom_range(0, 20));
        else
            s.elapsed_ms = pbmd_pkg::ELAPSED_W'($urandom_range(0, 255));
        return s;
    endfunction

    task automatic push_sample(input pbmd_pkg::sample_t s, input bit typed,
                               input pbmd_pkg::drive_t want);
        int gap;
        pbmd_pkg::drive_t pred;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        pred = next_drive(s);
        expected_q.push_back(typed ? want : pred);
    endtask

    task automatic finish_phase();
        sample_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input pbmd_pkg::reg_idx_t idx, input longint value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= pbmd_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            pbmd_pkg::REG_PROP_GAIN:    kp = value;
            pbmd_pkg::REG_INTEG_GAIN:   ki = value;
            pbmd_pkg::REG_DERIV_GAIN:   kd = value;
            pbmd_pkg::REG_TARGET_ANGLE: target = value;
            pbmd_pkg::REG_SPIN_OFFSET:  spin = value;
            pbmd_pkg::REG_DERIV_PERIOD: period = value & 8'hFF;
            default: ;
        endcase
    endtask

    task automatic load_config(input longint p, input longint i, input longint d,
                               input longint tgt, input longint spn, input longint per);
        write_reg(pbmd_pkg::REG_PROP_GAIN, p);
        write_reg(pbmd_pkg::REG_INTEG_GAIN, i);
        write_reg(pbmd_pkg::REG_DERIV_GAIN, d);
        write_reg(pbmd_pkg::REG_TARGET_ANGLE, tgt);
        write_reg(pbmd_pkg::REG_SPIN_OFFSET, spn);
        write_reg(pbmd_pkg::REG_DERIV_PERIOD, per);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // drive checker
    always @(posedge clk)
    begin
        pbmd_pkg::drive_t want;
        if (rst_n && drive_valid && drive_ready)
        begin
            if (expected_q.size() == 0)
                note_mismatch("unexpected drive transaction", 0, longint'(drive));
            else
            begin
                want = expected_q.pop_front();
                if (drive.motor_a_pwm !== want.motor_a_pwm)
                    note_mismatch("motor_a_pwm", want.motor_a_pwm, drive.motor_a_pwm);
                if (drive.motor_b_pwm !== want.motor_b_pwm)
                    note_mismatch("motor_b_pwm", want.motor_b_pwm, drive.motor_b_pwm);
                if (drive.drive_direction !== want.drive_direction)
                    note_mismatch("drive_direction", want.drive_direction,
                                  drive.drive_direction);
                if (drive.control_value !== want.control_value)
                    note_mismatch("control_value", $signed(want.control_value),
                                  $signed(drive.control_value));
                if (drive.telemetry_byte !== want.telemetry_byte)
                    note_mismatch("telemetry_byte", want.telemetry_byte,
                                  drive.telemetry_byte);
            end
        end
    end

    // drive receiver with random stalls and one long hold-off
    initial
    begin
        int stall;
        stall = 0;
        drive_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                drive_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (stall > 0)
            begin
                drive_ready <= 1'b0;
                stall--;
            end
            else
            begin
                drive_ready <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    rx_steady = !rx_steady;
                stall = rx_steady ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("pid_balance_motor_drive test failed");
            $finish;
        end
    end

    initial
    begin
        pbmd_pkg::sample_t s;
        int ph;
        int n;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        kp = 2330;
        ki = 2048;
        kd = 1280;
        target = 0;
        spin = 0;
        period = 10;
        integ_acc = 0;
        last_err = 0;
        deriv_ms = 0;
        held_a = 8'd255;
        held_b = 8'd255;
        held_dir = pbmd_pkg::DIR_STOP;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < NUM_ROWS; n++)
        begin
            s.tilt_angle = DIRECTED[n].tilt;
            s.elapsed_ms = DIRECTED[n].elapsed;
            push_sample(s, DIRECTED[n].typed, DIRECTED[n].want);
        end
        finish_phase();

        // drive the integral into its upper clamp, then cancel it exactly
        // so the pid sum is zero and the previous drive is held
        load_config(256, 32767, 0, 0, 0, 255);
        s.tilt_angle = 17'sd46080;
        s.elapsed_ms = 8'd1;
        repeat (3) push_sample(s, 1'b0, NO_DRIVE);
        finish_phase();
        load_config(256, 0, 0, 19200, 0, 255);
        s.tilt_angle = -17'sd46080;
        s.elapsed_ms = 8'd0;
        push_sample(s, 1'b0, NO_DRIVE);
        finish_phase();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: load_config(2330, 2048, 1280, 0, 0, 10);
                1: load_config(32767, 32767, 32767, -TILT_MAX, 255, 255);
                2: load_config(-32768, -32768, -32768, TILT_MAX, -255, 0);
                3: load_config(rand_gain(), rand_gain(), rand_gain(),
                               longint'($urandom_range(0, 32'(2 * TILT_MAX))) - TILT_MAX,
                               longint'($urandom_range(0, 510)) - 255, 1);
                default: load_config(rand_gain(), rand_gain(), rand_gain(),
                                     longint'($urandom_range(0, 32'(2 * TILT_MAX)))
                                     - TILT_MAX,
                                     longint'($urandom_range(0, 510)) - 255,
                                     longint'($urandom_range(0, 255)));
            endcase
            tx_steady = (ph == 1) || ($urandom_range(0, 3) == 0);
            if (ph == 1)
                hold_off_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                push_sample(random_sample(), 1'b0, NO_DRIVE);
            finish_phase();
        end

        repeat (2 * pbmd_pkg::NUM_STAGES) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("pid_balance_motor_drive test passed");
        else
            $display("pid_balance_motor_drive test failed");
        $finish;
    end

endmodule
